// ===== rtl/gost_block_cipher_ecb_core_defines.svh =====
// ----------------------------------------------------------------------------
// gost block cipher core assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef GOST_BLOCK_CIPHER_ECB_CORE_DEFINES_SVH
`define GOST_BLOCK_CIPHER_ECB_CORE_DEFINES_SVH

// same-cycle implication
`define GBC_ASSERT_NOW(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("gost core assertion failed");

// next-cycle implication
`define GBC_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("gost core assertion failed");

`endif

// ===== rtl/gbc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbc_pkg
// constants, s-box table and round helpers of the gost block cipher core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbc_pkg;

    localparam int unsigned ROUNDS    = 32;
    localparam int unsigned KEY_WORDS = 8;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned BLOCK_W   = 2 * HALF_W;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned KEY_IDX_W = $clog2(KEY_WORDS);
    localparam int unsigned ROUND_W   = $clog2(ROUNDS);
    localparam int unsigned ROT_L     = 11;

    typedef logic [HALF_W-1:0]    t_half;
    typedef logic [BLOCK_W-1:0]   t_block;
    typedef logic [KEY_IDX_W-1:0] t_key_idx;
    typedef logic [ROUND_W-1:0]   t_round;
    typedef logic [3:0]           t_nib;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    localparam t_nib SBOX [8][16] = '{
        '{4'd9,  4'd6,  4'd3,  4'd2,  4'd8,  4'd1,  4'd7,  4'd4,
          4'd15, 4'd12, 4'd0,  4'd5,  4'd10, 4'd11, 4'd13, 4'd14},
        '{4'd3,  4'd14, 4'd9,  4'd8,  4'd15, 4'd0,  4'd5,  4'd2,
          4'd6,  4'd11, 4'd4,  4'd1,  4'd7,  4'd10, 4'd13, 4'd12},
        '{4'd14, 4'd6,  4'd2,  4'd3,  4'd13, 4'd8,  4'd15, 4'd5,
          4'd0,  4'd7,  4'd9,  4'd11, 4'd4,  4'd1,  4'd10, 4'd12},
        '{4'd7,  4'd10, 4'd12, 4'd13, 4'd1,  4'd3,  4'd9,  4'd0,
          4'd2,  4'd14, 4'd15, 4'd8,  4'd5,  4'd6,  4'd11, 4'd4},
        '{4'd11, 4'd5,  4'd1,  4'd9,  4'd8,  4'd15, 4'd14, 4'd4,
          4'd2,  4'd3,  4'd12, 4'd7,  4'd6,  4'd10, 4'd13, 4'd0},
        '{4'd3,  4'd13, 4'd12, 4'd1,  4'd0,  4'd7,  4'd5,  4'd9,
          4'd4,  4'd8,  4'd15, 4'd6,  4'd2,  4'd11, 4'd14, 4'd10},
        '{4'd1,  4'd2,  4'd9,  4'd0,  4'd6,  4'd8,  4'd12, 4'd4,
          4'd5,  4'd1,  4'd3,  4'd7,  4'd14, 4'd10, 4'd13, 4'd11},
        '{4'd11, 4'd2,  4'd5,  4'd14, 4'd0,  4'd6,  4'd8,  4'd12,
          4'd4,  4'd5,  4'd1,  4'd3,  4'd7,  4'd9,  4'd13, 4'd15}
    };

    // add key, substitute nibbles (row 0 on the top nibble), rotate left
    function automatic t_half f_round(input t_half half, input t_half key);
        t_half x;
        t_half y;
        x = half + key;
        for (int n = 0; n < 8; n++) begin
            y[(7-n)*4 +: 4] = SBOX[n][x[(7-n)*4 +: 4]];
        end
        return {y[HALF_W-ROT_L-1:0], y[HALF_W-1:HALF_W-ROT_L]};
    endfunction

    // key word of a round; decryption runs with halves swapped, so its
    // schedule is 0..7 once and then 7..0 three times
    function automatic t_key_idx f_key_idx(input t_round rnd, input t_op op);
        logic rev;
        rev = (op == OP_DECRYPT) ? (rnd >= t_round'(8)) : (rnd >= t_round'(24));
        return rev ? ~rnd[KEY_IDX_W-1:0] : rnd[KEY_IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/gost_block_cipher_ecb_core.sv =====
// ----------------------------------------------------------------------------
// gost_block_cipher_ecb_core
// 64-bit gost 28147-89 block cipher, electronic codebook, fully pipelined
// ----------------------------------------------------------------------------
// One item is taken on every clock edge at which start is high; busy stays
// low. The 32 feistel rounds are unrolled into 32 register stages, with one
// entry register in front and one output register behind; block_out passes
// through all of them in order and is strobed by o_valid for one cycle.
// The output cannot be held off and must be taken in that cycle. Key
// words are written through the config port (index 0..7, higher indexes
// ignored) and may change only while no item is in flight.
`timescale 1ns / 1ps

`include "gost_block_cipher_ecb_core_defines.svh"

module gost_block_cipher_ecb_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_operation,
    input  logic [gbc_pkg::BLOCK_W-1:0]    i_block_in,
    output logic                           o_valid,
    output logic [gbc_pkg::BLOCK_W-1:0]    o_block_out,
    input  logic                           i_cfg_we,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbc_pkg::HALF_W-1:0]     i_cfg_wdata
);
    import gbc_pkg::*;

    localparam int unsigned LATENCY = ROUNDS + 2;

    t_half  r_key [KEY_WORDS];

    logic   r_vld [ROUNDS+1];
    t_op    r_op  [ROUNDS+1];
    t_half  r_lh  [ROUNDS+1];
    t_half  r_rh  [ROUNDS+1];

    t_half  n_lh  [ROUNDS];
    t_half  n_rh  [ROUNDS];

    logic   r_out_vld;
    t_block r_out;

    assign busy        = 1'b0;
    assign o_valid     = r_out_vld;
    assign o_block_out = r_out;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_WORDS; k++) begin
                r_key[k] <= '0;
            end
        end else begin
            for (int k = 0; k < KEY_WORDS; k++) begin
                if (i_cfg_we && (i_cfg_index == CFG_IDX_W'(k))) begin
                    r_key[k] <= i_cfg_wdata;
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= ROUNDS; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            r_vld[0] <= start && !busy;
            for (int s = 1; s <= ROUNDS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_vld <= r_vld[ROUNDS];
        end
    end

    // entry stage: decryption runs the same rounds on swapped halves
    always_ff @(posedge i_clk) begin
        r_op[0] <= t_op'(i_operation);
        if (t_op'(i_operation) == OP_DECRYPT) begin
            r_lh[0] <= i_block_in[HALF_W-1:0];
            r_rh[0] <= i_block_in[BLOCK_W-1:HALF_W];
        end else begin
            r_lh[0] <= i_block_in[BLOCK_W-1:HALF_W];
            r_rh[0] <= i_block_in[HALF_W-1:0];
        end
    end

    // round stages
    for (genvar j = 0; j < ROUNDS; j++) begin : g_round
        localparam t_key_idx KEY_ENC = f_key_idx(t_round'(j), OP_ENCRYPT);
        localparam t_key_idx KEY_DEC = f_key_idx(t_round'(j), OP_DECRYPT);

        t_half w_key;

        assign w_key   = (r_op[j] == OP_DECRYPT) ? r_key[KEY_DEC] : r_key[KEY_ENC];
        assign n_lh[j] = r_rh[j] ^ f_round(r_lh[j], w_key);
        assign n_rh[j] = r_lh[j];

        always_ff @(posedge i_clk) begin
            r_op[j+1] <= r_op[j];
            r_lh[j+1] <= n_lh[j];
            r_rh[j+1] <= n_rh[j];
        end
    end

    // output stage: undo the swap for decryption
    always_ff @(posedge i_clk) begin
        if (r_op[ROUNDS] == OP_DECRYPT) begin
            r_out <= {r_rh[ROUNDS], r_lh[ROUNDS]};
        end else begin
            r_out <= {r_lh[ROUNDS], r_rh[ROUNDS]};
        end
    end

    logic     w_key_wr;
    t_key_idx w_wr_idx;

    assign w_key_wr = i_cfg_we && (i_cfg_index < CFG_IDX_W'(KEY_WORDS));
    assign w_wr_idx = i_cfg_index[KEY_IDX_W-1:0];

    `GBC_ASSERT_NOW(a_out_from_start, o_valid, $past(start, LATENCY))
    `GBC_ASSERT_NEXT(a_last_round_to_out, r_vld[ROUNDS], o_valid)
    `GBC_ASSERT_NEXT(a_key_write, w_key_wr, r_key[$past(w_wr_idx)] == $past(i_cfg_wdata))

endmodule
